>>> hdl/jpeg_header_marker_parser_macros.svh
// ----------------------------------------------------------------------------
// jpeg header marker parser assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef JPEG_HEADER_MARKER_PARSER_MACROS_SVH
`define JPEG_HEADER_MARKER_PARSER_MACROS_SVH

// same-cycle implication
`define JHMP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jhmp assertion failed");

// next-cycle implication
`define JHMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jhmp assertion failed");

`endif

>>> hdl/jhmp_pkg.sv
// ----------------------------------------------------------------------------
// jhmp_pkg
// types and constants of the jpeg header marker parser
// ----------------------------------------------------------------------------
`default_nettype none

package jhmp_pkg;

    typedef enum logic [3:0] {
        PH_SOI_HI,
        PH_SOI_LO,
        PH_HUNT,
        PH_MARKER,
        PH_SOF_LHI,
        PH_SOF_LLO,
        PH_SOF_PREC,
        PH_SOF_HHI,
        PH_SOF_HLO,
        PH_SOF_WHI,
        PH_SOF_WLO,
        PH_SOF_NC,
        PH_SOF_COMP,
        PH_SEG_LHI,
        PH_SEG_LLO,
        PH_SEG_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_JPEG  = 3'd1,
        ST_EARLY_END = 3'd2,
        ST_BAD_SOF   = 3'd3,
        ST_BAD_LEN   = 3'd4
    } status_t;

    localparam logic [15:0] SOI_WORD      = 16'hFFD8;
    localparam logic [7:0]  MARKER_PREFIX = 8'hFF;
    localparam logic [7:0]  SOF_MASK      = 8'hF0;
    localparam logic [7:0]  SOF_BASE      = 8'hC0;
    localparam logic [7:0]  CODE_DHT      = 8'hC4;
    localparam logic [7:0]  CODE_DAC      = 8'hCC;
    localparam logic [7:0]  CODE_SOS      = 8'hDA;
    localparam logic [7:0]  CODE_EOI      = 8'hD9;
    localparam logic [15:0] MIN_LENGTH    = 16'd2;
    localparam logic [10:0] SOF_FIXED_LEN = 11'd8;
    localparam logic [15:0] COMP_BYTES    = 16'd3;

endpackage

`default_nettype wire

>>> hdl/jpeg_header_marker_parser.sv
// ----------------------------------------------------------------------------
// jpeg_header_marker_parser
// byte-serial jpeg marker walker reporting status and frame size at sos, on error or at eoi
// ----------------------------------------------------------------------------
// usage
//   input stream s_axis: one file byte per transaction, tuser carries the
//   end-of-stream and new-file flags. new_file restarts the parser on that
//   same transaction, which is then the first byte (or the end) of a file.
//   output stream m_axis: at most one result per file, carrying status,
//   width and height, issued when sos or eoi is reached or on the first error.
// throughput and output timing
//   one byte per cycle while the output register is free or being emptied;
//   the marker state machine is combinational and a result appears on
//   m_axis in the cycle after the byte that caused it.
// reset
//   rst_n clears the parser to wait for the soi word and empties the output
//   register; a stream may start without new_file.
// stalls
//   the output register parts the two sides: while it holds a result that
//   the receiver has not taken, s_axis_tready drops; otherwise input flows
//   on even while the result is being taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jpeg_header_marker_parser_macros.svh"

module jpeg_header_marker_parser
    import jhmp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_axis_tuser,   // [0] end_of_stream, [1] new_file

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // [2:0] status, [18:3] image_width,
                                             // [34:19] image_height, [39:35] zero
);

    // parser state
    phase_t      phase_reg,           phase_next;
    logic [7:0]  high_byte_hold_reg,  high_byte_hold_next;
    logic [15:0] segment_length_reg,  segment_length_next;
    logic [15:0] bytes_left_reg,      bytes_left_next;
    logic [15:0] height_reg,          height_next;
    logic [15:0] width_reg,           width_next;
    logic [7:0]  components_left_reg, components_left_next;
    logic        finished_reg,        finished_next;

    // output register
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [15:0] out_width_reg;
    logic [15:0] out_height_reg;

    // current view of the state after an optional restart
    phase_t      cur_phase;
    logic [7:0]  cur_hold;
    logic [15:0] cur_seg_len;
    logic [15:0] cur_bytes_left;
    logic [15:0] cur_height;
    logic [15:0] cur_width;
    logic [7:0]  cur_comps;
    logic        cur_finished;

    logic        in_fire;
    logic [7:0]  data_byte;
    logic        end_of_stream;
    logic        new_file;
    logic [15:0] word;
    logic [10:0] sof_expected_len;
    logic [15:0] bytes_dec;
    logic [7:0]  comps_dec;
    logic        result_valid;
    status_t     result_status;

    assign data_byte     = s_axis_tdata;
    assign end_of_stream = s_axis_tuser[0];
    assign new_file      = s_axis_tuser[1];

    // take a byte whenever the output register is free or being emptied
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // new_file acts before the byte is parsed
    always_comb
    begin
        if (new_file)
        begin
            cur_phase      = PH_SOI_HI;
            cur_hold       = 8'd0;
            cur_seg_len    = 16'd0;
            cur_bytes_left = 16'd0;
            cur_height     = 16'd0;
            cur_width      = 16'd0;
            cur_comps      = 8'd0;
            cur_finished   = 1'b0;
        end
        else
        begin
            cur_phase      = phase_reg;
            cur_hold       = high_byte_hold_reg;
            cur_seg_len    = segment_length_reg;
            cur_bytes_left = bytes_left_reg;
            cur_height     = height_reg;
            cur_width      = width_reg;
            cur_comps      = components_left_reg;
            cur_finished   = finished_reg;
        end
    end

    assign word             = {cur_hold, data_byte};
    assign sof_expected_len = SOF_FIXED_LEN + 11'(data_byte) * 11'd3;
    assign bytes_dec        = cur_bytes_left - 16'd1;
    assign comps_dec        = cur_comps - 8'd1;

    // marker state machine: next state and result
    always_comb
    begin
        phase_next           = cur_phase;
        high_byte_hold_next  = cur_hold;
        segment_length_next  = cur_seg_len;
        bytes_left_next      = cur_bytes_left;
        height_next          = cur_height;
        width_next           = cur_width;
        components_left_next = cur_comps;
        finished_next        = cur_finished;
        result_valid         = 1'b0;
        result_status        = ST_OK;

        if (cur_finished)
        begin
            // hold everything until the next file
        end
        else if (end_of_stream)
        begin
            result_valid = 1'b1;
            if (cur_phase == PH_SOI_HI || cur_phase == PH_SOI_LO)
                result_status = ST_NOT_JPEG;
            else
                result_status = ST_EARLY_END;
        end
        else
        begin
            case (cur_phase)
                PH_SOI_HI:
                begin
                    high_byte_hold_next = data_byte;
                    phase_next          = PH_SOI_LO;
                end
                PH_SOI_LO:
                begin
                    if (word != SOI_WORD)
                    begin
                        result_valid  = 1'b1;
                        result_status = ST_NOT_JPEG;
                    end
                    else
                        phase_next = PH_HUNT;
                end
                PH_HUNT:
                begin
                    if (data_byte == MARKER_PREFIX)
                        phase_next = PH_MARKER;
                end
                PH_MARKER:
                begin
                    if (data_byte == MARKER_PREFIX)
                    begin
                        // fill byte, stay
                    end
                    else if ((data_byte & SOF_MASK) == SOF_BASE
                             && data_byte != CODE_DHT && data_byte != CODE_DAC)
                        phase_next = PH_SOF_LHI;
                    else if (data_byte == CODE_SOS || data_byte == CODE_EOI)
                    begin
                        result_valid  = 1'b1;
                        result_status = ST_OK;
                    end
                    else
                        phase_next = PH_SEG_LHI;
                end
                PH_SOF_LHI:
                begin
                    high_byte_hold_next = data_byte;
                    phase_next          = PH_SOF_LLO;
                end
                PH_SOF_LLO:
                begin
                    segment_length_next = word;
                    if (word < MIN_LENGTH)
                    begin
                        result_valid  = 1'b1;
                        result_status = ST_BAD_LEN;
                    end
                    else
                        phase_next = PH_SOF_PREC;
                end
                PH_SOF_PREC:
                begin
                    phase_next = PH_SOF_HHI;
                end
                PH_SOF_HHI:
                begin
                    high_byte_hold_next = data_byte;
                    phase_next          = PH_SOF_HLO;
                end
                PH_SOF_HLO:
                begin
                    height_next = word;
                    phase_next  = PH_SOF_WHI;
                end
                PH_SOF_WHI:
                begin
                    high_byte_hold_next = data_byte;
                    phase_next          = PH_SOF_WLO;
                end
                PH_SOF_WLO:
                begin
                    width_next = word;
                    phase_next = PH_SOF_NC;
                end
                PH_SOF_NC:
                begin
                    if (cur_seg_len != {5'd0, sof_expected_len})
                    begin
                        result_valid  = 1'b1;
                        result_status = ST_BAD_SOF;
                    end
                    else
                    begin
                        components_left_next = data_byte;
                        bytes_left_next      = COMP_BYTES;
                        phase_next = (data_byte == 8'd0) ? PH_HUNT : PH_SOF_COMP;
                    end
                end
                PH_SOF_COMP:
                begin
                    if (bytes_dec == 16'd0)
                    begin
                        components_left_next = comps_dec;
                        if (comps_dec == 8'd0)
                        begin
                            bytes_left_next = 16'd0;
                            phase_next      = PH_HUNT;
                        end
                        else
                            bytes_left_next = COMP_BYTES;
                    end
                    else
                        bytes_left_next = bytes_dec;
                end
                PH_SEG_LHI:
                begin
                    high_byte_hold_next = data_byte;
                    phase_next          = PH_SEG_LLO;
                end
                PH_SEG_LLO:
                begin
                    segment_length_next = word;
                    if (word < MIN_LENGTH)
                    begin
                        result_valid  = 1'b1;
                        result_status = ST_BAD_LEN;
                    end
                    else
                    begin
                        bytes_left_next = word - MIN_LENGTH;
                        phase_next = (word == MIN_LENGTH) ? PH_HUNT : PH_SEG_SKIP;
                    end
                end
                PH_SEG_SKIP:
                begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 16'd0)
                        phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_SOI_HI;
                end
            endcase
        end

        if (result_valid)
            finished_next = 1'b1;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_SOI_HI;
            high_byte_hold_reg  <= 8'd0;
            segment_length_reg  <= 16'd0;
            bytes_left_reg      <= 16'd0;
            height_reg          <= 16'd0;
            width_reg           <= 16'd0;
            components_left_reg <= 8'd0;
            finished_reg        <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg           <= phase_next;
            high_byte_hold_reg  <= high_byte_hold_next;
            segment_length_reg  <= segment_length_next;
            bytes_left_reg      <= bytes_left_next;
            height_reg          <= height_next;
            width_reg           <= width_next;
            components_left_reg <= components_left_next;
            finished_reg        <= finished_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && result_valid)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire && result_valid)
        begin
            out_status_reg <= result_status;
            out_width_reg  <= cur_width;
            out_height_reg <= cur_height;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_height_reg, out_width_reg, out_status_reg};

    // input only stalls behind a result the receiver is refusing
    `JHMP_ASSERT_IMPL(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    // a result marks the file finished and lands in the output register
    `JHMP_ASSERT_NEXT(a_result_loaded, in_fire && result_valid,
                      finished_reg && m_axis_tvalid)
    // component skipping always has work left and a byte count of one to three
    `JHMP_ASSERT_IMPL(a_comp_counts, phase_reg == PH_SOF_COMP,
                      components_left_reg != 8'd0 && bytes_left_reg != 16'd0
                      && bytes_left_reg <= COMP_BYTES)
    // once finished, bytes of the same file leave the parser untouched
    `JHMP_ASSERT_NEXT(a_finished_hold, in_fire && finished_reg && !new_file,
                      $stable(phase_reg) && $stable(width_reg) && $stable(height_reg))

endmodule

`default_nettype wire

>>> tb/jpeg_header_marker_parser_checker.sv
// ----------------------------------------------------------------------------
// jpeg header marker parser checker
// watches both streams, predicts every result from the accepted bytes and
// compares each delivered result with the oldest one still owed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jpeg_header_marker_parser_checker
    import jhmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [0] end_of_stream, [1] new_file

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // [2:0] status, [18:3] image_width,
                                        // [34:19] image_height, [39:35] zero

    output int          error_count,
    output int          pending_results
);

    typedef struct {
        status_t     status;
        logic [15:0] width;
        logic [15:0] height;
    } frame_report_t;

    frame_report_t report_q[$];
    frame_report_t owed;

    // shadow copy of the parser state
    phase_t      stage;
    logic [7:0]  hi_byte;
    logic [15:0] seg_len;
    logic [15:0] skip_count;
    logic [15:0] frame_h;
    logic [15:0] frame_w;
    logic [7:0]  comps_left;
    logic        done;

    int errors = 0;
    int results_seen = 0;

    task automatic clear_parser();
        stage      = PH_SOI_HI;
        hi_byte    = '0;
        seg_len    = '0;
        skip_count = '0;
        frame_h    = '0;
        frame_w    = '0;
        comps_left = '0;
        done       = 1'b0;
    endtask

    task automatic conclude(input status_t st);
        report_q.push_back('{st, frame_w, frame_h});
        done = 1'b1;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eos, input logic nf);
        logic [15:0] word;
        word = {hi_byte, b};
        if (nf)
            clear_parser();
        if (done)
            return;
        if (eos)
        begin
            if (stage == PH_SOI_HI || stage == PH_SOI_LO)
                conclude(ST_NOT_JPEG);
            else
                conclude(ST_EARLY_END);
            return;
        end
        case (stage)
            PH_SOI_HI:
            begin
                hi_byte = b;
                stage   = PH_SOI_LO;
            end
            PH_SOI_LO:
            begin
                if (word != SOI_WORD)
                    conclude(ST_NOT_JPEG);
                else
                    stage = PH_HUNT;
            end
            PH_HUNT:
            begin
                if (b == MARKER_PREFIX)
                    stage = PH_MARKER;
            end
            PH_MARKER:
            begin
                if (b == MARKER_PREFIX)
                    ;   // fill byte
                else if ((b & SOF_MASK) == SOF_BASE && b != CODE_DHT && b != CODE_DAC)
                    stage = PH_SOF_LHI;
                else if (b == CODE_SOS || b == CODE_EOI)
                    conclude(ST_OK);
                else
                    stage = PH_SEG_LHI;
            end
            PH_SOF_LHI:
            begin
                hi_byte = b;
                stage   = PH_SOF_LLO;
            end
            PH_SEG_LHI:
            begin
                hi_byte = b;
                stage   = PH_SEG_LLO;
            end
            PH_SOF_HHI:
            begin
                hi_byte = b;
                stage   = PH_SOF_HLO;
            end
            PH_SOF_WHI:
            begin
                hi_byte = b;
                stage   = PH_SOF_WLO;
            end
            PH_SOF_LLO:
            begin
                seg_len = word;
                if (word < MIN_LENGTH)
                    conclude(ST_BAD_LEN);
                else
                    stage = PH_SOF_PREC;
            end
            PH_SOF_PREC:
                stage = PH_SOF_HHI;
            PH_SOF_HLO:
            begin
                frame_h = word;
                stage   = PH_SOF_WHI;
            end
            PH_SOF_WLO:
            begin
                frame_w = word;
                stage   = PH_SOF_NC;
            end
            PH_SOF_NC:
            begin
                if (int'(seg_len) != 8 + 3 * int'(b))
                    conclude(ST_BAD_SOF);
                else
                begin
                    comps_left = b;
                    skip_count = 16'd3;
                    stage      = (b == 8'd0) ? PH_HUNT : PH_SOF_COMP;
                end
            end
            PH_SOF_COMP:
            begin
                skip_count = skip_count - 16'd1;
                if (skip_count == 16'd0)
                begin
                    comps_left = comps_left - 8'd1;
                    skip_count = 16'd3;
                    if (comps_left == 8'd0)
                    begin
                        skip_count = 16'd0;
                        stage      = PH_HUNT;
                    end
                end
            end
            PH_SEG_LLO:
            begin
                seg_len = word;
                if (word < MIN_LENGTH)
                    conclude(ST_BAD_LEN);
                else
                begin
                    skip_count = word - 16'd2;
                    stage      = (skip_count == 16'd0) ? PH_HUNT : PH_SEG_SKIP;
                end
            end
            default:
            begin
                skip_count = skip_count - 16'd1;
                if (skip_count == 16'd0)
                    stage = PH_HUNT;
            end
        endcase
    endtask

    initial
    begin
        clear_parser();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // a result is registered and shows on m_axis only after its byte, so compare before predicting
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (report_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("result %0d: none owed, got status %0d width %h height %h",
                                 results_seen, m_axis_tdata[2:0], m_axis_tdata[18:3],
                                 m_axis_tdata[34:19]);
                    errors++;
                end
                else
                begin
                    owed = report_q.pop_front();
                    if (m_axis_tdata[2:0] !== owed.status || m_axis_tdata[18:3] !== owed.width
                        || m_axis_tdata[34:19] !== owed.height || m_axis_tdata[39:35] !== 5'd0)
                    begin
                        if (errors < 10)
                        begin
                            $display("result %0d: expected status %0d width %h height %h",
                                     results_seen, owed.status, owed.width, owed.height);
                            $display("result %0d: got status %0d width %h height %h pad %b",
                                     results_seen, m_axis_tdata[2:0], m_axis_tdata[18:3],
                                     m_axis_tdata[34:19], m_axis_tdata[39:35]);
                        end
                        errors++;
                    end
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
        end
        error_count     <= errors;
        pending_results <= report_q.size();
    end

endmodule

>>> tb/jpeg_header_marker_parser_test.sv
// ----------------------------------------------------------------------------
// jpeg header marker parser test
// feeds byte streams of jpeg headers, well formed and broken, with random
// idling on both streams; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jpeg_header_marker_parser_test;

    import jhmp_pkg::*;

    // one input transaction: byte, end-of-stream flag, restart flag
    typedef struct packed {
        logic [7:0] b;
        logic       eos;
        logic       nf;
    } stream_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;    // [7:0] data_byte
    logic [1:0]  s_axis_tuser = 2'd0;    // [0] end_of_stream, [1] new_file

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [2:0] status, [18:3] image_width,
                                         // [34:19] image_height, [39:35] zero

    int          errors;
    int          pending;

    stream_item_t file_q[$];
    logic         calm_tx = 1'b0;        // no sender gaps while set

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    jpeg_header_marker_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    jpeg_header_marker_parser_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .error_count     (errors),
        .pending_results (pending)
    );

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(1, 2);
        if (r < 90)
            return $urandom_range(3, 6);
        return $urandom_range(12, 48);
    endfunction

    task automatic add(input logic [7:0] b);
        file_q.push_back({b, 1'b0, 1'b0});
    endtask

    task automatic add_word(input logic [15:0] w);
        add(w[15:8]);
        add(w[7:0]);
    endtask

    // end of stream; the byte lane carries junk that must be ignored
    task automatic add_end();
        file_q.push_back({8'($urandom_range(0, 255)), 1'b1, 1'b0});
    endtask

    // marker prefix with an occasional run of fill bytes
    task automatic add_prefix();
        int fills;
        fills = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        add(MARKER_PREFIX);
        repeat (fills)
            add(MARKER_PREFIX);
    endtask

    // one file into file_q; body_len counts the items before any trailing bytes
    task automatic build_file(output int body_len);
        int          r;
        int          nseg;
        int          nc;
        int          len;
        int          cut;
        logic [7:0]  code;
        logic [15:0] seg_word;
        file_q.delete();
        // start-of-image word, occasionally a wrong one
        if ($urandom_range(0, 99) < 6)
            add_word(16'($urandom_range(0, 65535)));
        else
            add_word(SOI_WORD);
        nseg = $urandom_range(0, 4);
        repeat (nseg)
        begin
            // stray bytes while hunting for a prefix
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    add(8'($urandom_range(0, 254)));
            add_prefix();
            r = $urandom_range(0, 19);
            if ($urandom_range(0, 99) < 45)
            begin
                // start of frame, any code of the family but dht and dac
                do
                    code = SOF_BASE | 8'($urandom_range(0, 15));
                while (code == CODE_DHT || code == CODE_DAC);
                nc  = ($urandom_range(0, 49) == 0) ? $urandom_range(4, 255)
                                                   : $urandom_range(0, 3);
                len = 8 + 3 * nc;
                if (r == 0)
                    len = $urandom_range(0, 1);
                else if (r == 1)
                    len = len + $urandom_range(1, 3);
                else if (r == 2)
                    len = $urandom_range(0, 65535);
                add(code);
                add_word(16'(len));
                add(8'($urandom_range(0, 255)));       // precision
                add_word(16'($urandom_range(0, 65535)));
                add_word(16'($urandom_range(0, 65535)));
                add(8'(nc));
                repeat (3 * nc)
                    add(8'($urandom_range(0, 255)));
            end
            else
            begin
                // any other segment, including 0x00, dht, dac and comments
                if ($urandom_range(0, 9) < 3)
                begin
                    case ($urandom_range(0, 3))
                        0: code = 8'h00;
                        1: code = CODE_DHT;
                        2: code = CODE_DAC;
                        default: code = 8'hFE;
                    endcase
                end
                else
                begin
                    do
                        code = 8'($urandom_range(0, 255));
                    while (code == MARKER_PREFIX || code == CODE_SOS || code == CODE_EOI
                           || ((code & SOF_MASK) == SOF_BASE && code != CODE_DHT
                               && code != CODE_DAC));
                end
                if (r == 0)
                    len = $urandom_range(0, 1);
                else if (r == 1)
                    len = $urandom_range(20, 60);
                else
                    len = $urandom_range(2, 6);
                seg_word = 16'(len);
                add(code);
                add_word(seg_word);
                if (len >= 2)
                    repeat (len - 2)
                        add(8'($urandom_range(0, 255)));
            end
        end
        // how the file ends
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            add_prefix();
            add(CODE_SOS);
        end
        else if (r < 72)
        begin
            add_prefix();
            add(CODE_EOI);
        end
        else if (r < 86)
            add_end();
        else
        begin
            // cut short; without an end the next restart lands mid-parse
            cut = $urandom_range(1, file_q.size() - 1);
            while (file_q.size() > cut)
                void'(file_q.pop_back());
            if ($urandom_range(0, 1) == 0)
                add_end();
        end
        file_q[0].nf = 1'b1;
        body_len = file_q.size();
        // trailing bytes, normally ignored once the result is out
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                add(8'($urandom_range(0, 255)));
    endtask

    // offer one transaction from the falling edge until it is taken
    task automatic send_item(input stream_item_t it);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.b;
        s_axis_tuser  <= {it.nf, it.eos};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        gap = (calm_tx || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
    endtask

    task automatic send_file();
        foreach (file_q[i])
            send_item(file_q[i]);
    endtask

    // stimulus and verdict
    initial
    begin
        int sent;
        int body_len;
        sent = 0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no restart after reset; frame with zero components and the largest size
        file_q.delete();
        add_word(SOI_WORD);
        add(MARKER_PREFIX);
        add(SOF_BASE);
        add_word(16'd8);
        add(8'd8);
        add_word(16'hFFFF);
        add_word(16'hFFFF);
        add(8'd0);
        add(MARKER_PREFIX);
        add(CODE_EOI);
        // after the result these are ignored
        add(MARKER_PREFIX);
        add(8'h00);
        // restart straight into an end: not jpeg, size cleared
        file_q.push_back({8'hFF, 1'b1, 1'b1});
        // marker code 0x00 taken as a segment, length below two
        file_q.push_back({8'hFF, 1'b0, 1'b1});
        add(SOI_WORD[7:0]);
        add(MARKER_PREFIX);
        add(8'h00);
        add_word(16'd1);
        // end after the soi word: premature end
        file_q.push_back({8'hFF, 1'b0, 1'b1});
        add(SOI_WORD[7:0]);
        add_end();
        send_file();

        // random files until enough bytes have gone in
        while (sent < 1700)
        begin
            build_file(body_len);
            calm_tx = ($urandom_range(0, 4) == 0);
            send_file();
            sent += body_len;
        end
        s_axis_tvalid <= 1'b0;

        // drain, then wait a little longer for anything stray
        while (pending != 0)
            @(negedge clk);
        repeat (10)
            @(negedge clk);
        if (errors == 0)
            $display("jpeg_header_marker_parser test passed");
        else
            $display("jpeg_header_marker_parser test failed");
        $finish;
    end

    // receiver: random stalls, calm stretches, and two long hold-offs that
    // fill the output register and push back on the sender
    initial
    begin
        int cycle;
        int stall;
        cycle = 0;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cycle++;
            if ((cycle >= 60 && cycle < 360) || (cycle >= 4000 && cycle < 4400))
                m_axis_tready <= 1'b0;
            else if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (((cycle / 700) % 3) != 2 && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("jpeg_header_marker_parser test failed");
        $finish;
    end

endmodule

>>> jpeg_header_marker_parser.f
+incdir+hdl
hdl/jhmp_pkg.sv
hdl/jpeg_header_marker_parser.sv
tb/jpeg_header_marker_parser_checker.sv
tb/jpeg_header_marker_parser_test.sv
